### rtl/rec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rotary embedding cos/sin generator.
// No dependencies; imported by rotary_embedding_cos_sin.
package rec_pkg;

	localparam int unsigned POS_W    = 16;
	localparam int unsigned FREQ_W   = 32;
	localparam int unsigned SCALE_W  = 16;
	localparam int unsigned IDX_W    = 6;
	localparam int unsigned VAL_W    = 16;
	localparam int unsigned ANG_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [FREQ_W-1:0]  FREQ_BASE_RST    = 32'd683565276;
	localparam logic [FREQ_W-1:0]  FREQ_RATIO_RST   = 32'd3719288384;
	localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RST = 16'd32768;

	// 0.6072529350 in Q2.30, the inverse CORDIC gain
	localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

	localparam int unsigned ATAN_LEN = 24;
	// atan(2^-k) in units of 2^-32 turn
	localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FREQ_BASE    = 2'd0,
		REG_FREQ_RATIO   = 2'd1,
		REG_OUTPUT_SCALE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

endpackage

### rtl/rotary_embedding_cos_sin.sv
`timescale 1ns / 1ps
// Rotary embedding cos/sin generator: frequency sequencer, phase multiply,
// pipelined CORDIC, scale and saturate. Depends on rec_pkg.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata[15:0] position
//  m_      | out | m_tvalid/m_tready | m_tdata freq_index,cos,sin; m_tlast last
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each position yields HALF_DIM items, one per cycle while m_tready does not stall the
// pipeline; the frequency recursion (one 32x32 multiply per item) sets that pace.
// A new position is taken in the cycle the previous one issues its last frequency.
// A stall on m_tready freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the valid bits and loads the register defaults; there is no clearing pass.
module rotary_embedding_cos_sin #(
	parameter int unsigned HALF_DIM      = 64,
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [rec_pkg::POS_W-1:0]            s_tdata,   // [15:0] position
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [5:0] freq_index, [21:6] cos_value, [37:22] sin_value, [39:38] zero
	output logic [rec_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rec_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                          cfg_data
);
	import rec_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HALF_DIM - 1);
	localparam int unsigned      NST      = CORDIC_STAGES;
	localparam int unsigned      PROD_W   = ANG_W + SCALE_W + 1;

	// configuration registers
	logic [FREQ_W-1:0]  freq_base_q;
	logic [FREQ_W-1:0]  freq_ratio_q;
	logic [SCALE_W-1:0] output_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_base_q    <= FREQ_BASE_RST;
			freq_ratio_q   <= FREQ_RATIO_RST;
			output_scale_q <= OUTPUT_SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FREQ_BASE:    freq_base_q    <= cfg_data;
				REG_FREQ_RATIO:   freq_ratio_q   <= cfg_data;
				REG_OUTPUT_SCALE: output_scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the output register is held
	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	// frequency sequencer
	logic              busy_q;
	logic [POS_W-1:0]  pos_q;
	logic [FREQ_W-1:0] freq_q;
	logic [IDX_W-1:0]  idx_q;
	logic              seq_last;
	logic              accept;
	logic [2*FREQ_W-1:0] freq_prod;

	assign seq_last  = (idx_q == LAST_IDX);
	assign s_tready  = !busy_q || (adv && seq_last);
	assign accept    = s_tvalid && s_tready;
	assign freq_prod = freq_q * freq_ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (adv && seq_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= s_tdata;
			freq_q <= freq_base_q;
			idx_q  <= '0;
		end else if (adv && busy_q) begin
			freq_q <= freq_prod[2*FREQ_W-1:FREQ_W];
			idx_q  <= idx_q + 1'b1;
		end
	end

	// stage 1: position, frequency, index
	logic              v_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [FREQ_W-1:0] freq_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              last_s1;

	// stage 2: phase
	logic              v_s2;
	logic [ANG_W-1:0]  phase_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic              last_s2;
	logic [POS_W+FREQ_W-1:0] phase_prod;

	assign phase_prod = pos_s1 * freq_s1;

	// stage 3 onwards: quadrant split then one rotation per stage, entry k at stage 3+k
	logic                    v_s3    [NST+1];
	logic signed [ANG_W-1:0] x_s3    [NST+1];
	logic signed [ANG_W-1:0] y_s3    [NST+1];
	logic signed [ANG_W-1:0] z_s3    [NST+1];
	quad_t                   quad_s3 [NST+1];
	logic [IDX_W-1:0]        idx_s3  [NST+1];
	logic                    last_s3 [NST+1];

	logic [ANG_W-1:0] phase_off;
	quad_t            quad_in;

	assign phase_off = phase_s2 + 32'h20000000;
	assign quad_in   = quad_t'(phase_off[ANG_W-1:ANG_W-2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3[0] <= 1'b0;
		end else if (adv) begin
			v_s1    <= busy_q;
			v_s2    <= v_s1;
			v_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1     <= pos_q;
			freq_s1    <= freq_q;
			idx_s1     <= idx_q;
			last_s1    <= seq_last;
			phase_s2   <= phase_prod[ANG_W-1:0];
			idx_s2     <= idx_s1;
			last_s2    <= last_s1;
			x_s3[0]    <= CORDIC_GAIN_Q30;
			y_s3[0]    <= '0;
			z_s3[0]    <= $signed(phase_s2 - {quad_in, {(ANG_W-2){1'b0}}});
			quad_s3[0] <= quad_in;
			idx_s3[0]  <= idx_s2;
			last_s3[0] <= last_s2;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_rot
		logic signed [ANG_W-1:0] dx;
		logic signed [ANG_W-1:0] dy;
		logic signed [ANG_W-1:0] at;

		assign dx = y_s3[k] >>> k;
		assign dy = x_s3[k] >>> k;
		assign at = $signed(ATAN_TURNS[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k+1] <= 1'b0;
			end else if (adv) begin
				v_s3[k+1] <= v_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_s3[k][ANG_W-1]) begin
					x_s3[k+1] <= x_s3[k] - dx;
					y_s3[k+1] <= y_s3[k] + dy;
					z_s3[k+1] <= z_s3[k] - at;
				end else begin
					x_s3[k+1] <= x_s3[k] + dx;
					y_s3[k+1] <= y_s3[k] - dy;
					z_s3[k+1] <= z_s3[k] + at;
				end
				quad_s3[k+1] <= quad_s3[k];
				idx_s3[k+1]  <= idx_s3[k];
				last_s3[k+1] <= last_s3[k];
			end
		end
	end

	// quadrant fix
	logic                    v_fx;
	logic signed [ANG_W-1:0] cos_fx, sin_fx;
	logic [IDX_W-1:0]        idx_fx;
	logic                    last_fx;
	logic signed [ANG_W-1:0] cos_nx, sin_nx;
	logic signed [ANG_W-1:0] xe, ye;

	assign xe = x_s3[NST];
	assign ye = y_s3[NST];

	always_comb begin
		unique case (quad_s3[NST])
			QUAD_0: begin cos_nx = xe;  sin_nx = ye;  end
			QUAD_1: begin cos_nx = -ye; sin_nx = xe;  end
			QUAD_2: begin cos_nx = -xe; sin_nx = -ye; end
			QUAD_3: begin cos_nx = ye;  sin_nx = -xe; end
			default: begin cos_nx = xe; sin_nx = ye; end
		endcase
	end

	// scale multiply
	logic                     v_mu;
	logic signed [PROD_W-1:0] cos_mu, sin_mu;
	logic [IDX_W-1:0]         idx_mu;
	logic                     last_mu;
	logic signed [SCALE_W:0]  scale_sx;

	assign scale_sx = $signed({1'b0, output_scale_q});

	// round, shift and saturate
	localparam int unsigned RND_W = PROD_W - 30;
	logic signed [PROD_W-1:0] cos_rn, sin_rn;
	logic signed [RND_W-1:0]  cos_sh, sin_sh;
	logic signed [VAL_W-1:0]  cos_sat, sin_sat;

	assign cos_rn = cos_mu + PROD_W'(33'sh20000000);
	assign sin_rn = sin_mu + PROD_W'(33'sh20000000);
	assign cos_sh = cos_rn[PROD_W-1:30];
	assign sin_sh = sin_rn[PROD_W-1:30];

	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [RND_W-1:0] v);
		logic signed [RND_W-1:0] hi, lo;
		hi = RND_W'(32767);
		lo = -RND_W'(32768);
		if (v > hi)
			sat16 = 16'sh7FFF;
		else if (v < lo)
			sat16 = 16'sh8000;
		else
			sat16 = v[VAL_W-1:0];
	endfunction

	assign cos_sat = sat16(cos_sh);
	assign sin_sat = sat16(sin_sh);

	logic [VAL_W-1:0] cos_out_q, sin_out_q;
	logic [IDX_W-1:0] idx_out_q;
	logic             last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_fx        <= 1'b0;
			v_mu        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_fx        <= v_s3[NST];
			v_mu        <= v_fx;
			out_valid_q <= v_mu;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_fx     <= cos_nx;
			sin_fx     <= sin_nx;
			idx_fx     <= idx_s3[NST];
			last_fx    <= last_s3[NST];
			cos_mu     <= cos_fx * scale_sx;
			sin_mu     <= sin_fx * scale_sx;
			idx_mu     <= idx_fx;
			last_mu    <= last_fx;
			cos_out_q  <= cos_sat;
			sin_out_q  <= sin_sat;
			idx_out_q  <= idx_mu;
			last_out_q <= last_mu;
		end
	end

	assign m_tdata = {2'b00, sin_out_q, cos_out_q, idx_out_q};
	assign m_tlast = last_out_q;

endmodule

### dv/tb_rotary_embedding_cos_sin.sv
`timescale 1ns / 1ps
// Testbench for rotary_embedding_cos_sin: streams token positions, predicts every
// frequency's cos/sin item in a local CORDIC model and checks them in order.
// Depends on rec_pkg and the RTL top level only.
module tb_rotary_embedding_cos_sin;
	import rec_pkg::*;

	localparam int unsigned HALF_DIM      = 64;
	localparam int unsigned CORDIC_STAGES = 16;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;  // unmapped index, write is dropped
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 100;
	localparam int ITEMS_PER_BATCH = 40;

	localparam logic [POS_W-1:0] EDGE_POS [8] = '{
		16'd0, 16'd1, 16'd2, 16'd3, 16'd255, 16'd256, 16'd32768, 16'd65535
	};
	localparam logic [POS_W-1:0] QUAD_POS [6] = '{
		16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd65535
	};
	localparam logic [POS_W-1:0] WRAP_POS [4] = '{
		16'd1, 16'h5555, 16'hAAAA, 16'hFFFF
	};

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] cos_v;
		logic signed [VAL_W-1:0] sin_v;
		logic                    last;
	} rot_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [POS_W-1:0]      s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [31:0]           cfg_data = '0;

	// local copy of the register file
	logic [FREQ_W-1:0]  cfg_freq_base  = FREQ_BASE_RST;
	logic [FREQ_W-1:0]  cfg_freq_ratio = FREQ_RATIO_RST;
	logic [SCALE_W-1:0] cfg_scale      = OUTPUT_SCALE_RST;

	logic [POS_W-1:0]            pos_q[$];
	logic [CFG_IDX_W+31:0]       reg_write_q[$];
	rot_result_t                 rot_expect_q[$];
	rot_result_t                 got, want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int items_taken = 0;
	int results_seen = 0;
	int regs_written = 0;
	int quiet_cycles = 0;

	rotary_embedding_cos_sin #(
		.HALF_DIM      (HALF_DIM),
		.CORDIC_STAGES (CORDIC_STAGES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [15:0] position
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // [5:0] freq_index, [21:6] cos, [37:22] sin, [39:38] zero
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void cordic_rotate(input logic [ANG_W-1:0] phase,
			output longint c, output longint s);
		logic [ANG_W-1:0] shifted;
		logic [ANG_W-1:0] resid;
		quad_t            q;
		longint           x, y, z, dx, dy;
		shifted = phase + 32'h2000_0000;
		q = quad_t'(shifted[31:30]);
		// residual angle lies in [-1/8, 1/8) turn
		resid = phase - {shifted[31:30], 30'd0};
		z = longint'($signed(resid));
		x = longint'(CORDIC_GAIN_Q30);
		y = 0;
		for (int k = 0; k < int'(CORDIC_STAGES) && k < int'(ATAN_LEN); k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'({32'd0, ATAN_TURNS[k]});
			end else begin
				x += dx;
				y -= dy;
				z += longint'({32'd0, ATAN_TURNS[k]});
			end
		end
		case (q)
			QUAD_0: begin c = x; s = y; end
			QUAD_1: begin c = -y; s = x; end
			QUAD_2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] scale_sat(input longint c);
		longint v;
		v = (c * longint'({48'd0, cfg_scale}) + (longint'(1) <<< 29)) >>> 30;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	// Queue all HALF_DIM cos/sin items that one position produces.
	function automatic void predict_cos_sin(input logic [POS_W-1:0] pos);
		logic [FREQ_W-1:0] freq;
		logic [63:0]       prod;
		longint            c, s;
		rot_result_t       r;
		freq = cfg_freq_base;
		for (int i = 0; i < int'(HALF_DIM); i++) begin
			prod = {48'd0, pos} * {32'd0, freq};
			cordic_rotate(prod[31:0], c, s);
			r.idx   = IDX_W'(i);
			r.cos_v = scale_sat(c);
			r.sin_v = scale_sat(s);
			r.last  = (i == int'(HALF_DIM) - 1);
			rot_expect_q.insert(rot_expect_q.size(), r);
			prod = {32'd0, freq} * {32'd0, cfg_freq_ratio};
			freq = prod[63:32];
		end
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(9))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2, 3, 4: return POS_W'($urandom_range(0, 255));
			default: return POS_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Position driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_cos_sin(s_tdata);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pos_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata  <= pos_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Register write driver
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				regs_written++;
				case (cfg_index)
					REG_FREQ_BASE:    cfg_freq_base  <= cfg_data;
					REG_FREQ_RATIO:   cfg_freq_ratio <= cfg_data;
					REG_OUTPUT_SCALE: cfg_scale      <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_write_q.size() != 0) begin
					cfg_index <= reg_write_q[0][CFG_IDX_W+31:32];
					cfg_data  <= reg_write_q[0][31:0];
					cfg_valid <= 1'b1;
					void'(reg_write_q.pop_front());
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[5:0], m_tdata[21:6], m_tdata[37:22], m_tlast};
				if (rot_expect_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected item idx %0d cos %0d sin %0d last %0b",
						$time, got.idx, got.cos_v, got.sin_v, got.last);
				end else begin
					want = rot_expect_q.pop_front();
					results_seen++;
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected idx %0d cos %0d sin %0d last %0b",
							$time, want.idx, want.cos_v, want.sin_v, want.last);
						$display("%0t:          actual   idx %0d cos %0d sin %0d last %0b",
							$time, got.idx, got.cos_v, got.sin_v, got.last);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d items still expected",
				$time, rot_expect_q.size());
			$display("tb_rotary_embedding_cos_sin failed");
			$finish;
		end
	end

	// Wait until every queued position has gone in and all its items came out.
	task automatic drain_block();
		while (pos_q.size() != 0 || s_tvalid || rot_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		reg_write_q.insert(reg_write_q.size(), {idx, val});
		while (reg_write_q.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_idling(7, 71);

		// reset defaults, edge positions
		foreach (EDGE_POS[i])
			pos_q.insert(pos_q.size(), EDGE_POS[i]);
		drain_block();

		// eighth-turn base lands exactly on quadrant boundaries; scale above one saturates
		write_reg(REG_FREQ_BASE, 32'h2000_0000);
		write_reg(REG_FREQ_RATIO, 32'h8000_0000);
		write_reg(REG_OUTPUT_SCALE, 32'h0000_FFFF);
		foreach (QUAD_POS[i])
			pos_q.insert(pos_q.size(), QUAD_POS[i]);
		drain_block();

		// largest frequencies wrap the phase; zero scale
		write_reg(REG_FREQ_BASE, 32'hFFFF_FFFF);
		write_reg(REG_FREQ_RATIO, 32'hFFFF_FFFF);
		write_reg(REG_OUTPUT_SCALE, 32'h0000_0000);
		foreach (WRAP_POS[i])
			pos_q.insert(pos_q.size(), WRAP_POS[i]);
		drain_block();

		// zero ratio, smallest scale, and a write to an unmapped index that must be dropped
		write_reg(REG_FREQ_BASE, 32'h1234_5678);
		write_reg(REG_FREQ_RATIO, 32'h0000_0000);
		write_reg(REG_OUTPUT_SCALE, 32'h0000_0001);
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		pos_q.insert(pos_q.size(), 16'hFFFF);
		pos_q.insert(pos_q.size(), 16'd1);
		drain_block();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: set_idling(7, 71);
				1: set_idling(71, 7);
				default: set_idling(0, 0);
			endcase
			for (int b = 0; b < 2; b++) begin
				drain_block();
				case ($urandom_range(3))
					0: write_reg(REG_FREQ_BASE, $urandom());
					1: write_reg(REG_FREQ_BASE, FREQ_BASE_RST);
					2: write_reg(REG_FREQ_BASE, $urandom_range(0, 32'h00FF_FFFF));
					default: write_reg(REG_FREQ_BASE, $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
				endcase
				case ($urandom_range(3))
					0: write_reg(REG_FREQ_RATIO, $urandom());
					1: write_reg(REG_FREQ_RATIO, FREQ_RATIO_RST);
					2: write_reg(REG_FREQ_RATIO, 32'hF000_0000 | $urandom_range(0, 32'h0FFF_FFFF));
					default: write_reg(REG_FREQ_RATIO, 32'hFFFF_FFFF);
				endcase
				// upper data bits are junk for the 16-bit scale register
				case ($urandom_range(3))
					0: write_reg(REG_OUTPUT_SCALE, $urandom());
					1: write_reg(REG_OUTPUT_SCALE, {16'($urandom()), OUTPUT_SCALE_RST});
					2: write_reg(REG_OUTPUT_SCALE, $urandom_range(0, 32768));
					default: write_reg(REG_OUTPUT_SCALE, 32'h0000_FFFF);
				endcase
				for (int n = 0; n < ITEMS_PER_BATCH; n++) begin
					// hold the sender once until the pipeline is empty
					if (ph == 1 && b == 0 && n == ITEMS_PER_BATCH / 2)
						drain_block();
					pos_q.insert(pos_q.size(), pick_position());
				end
			end
		end

		drain_block();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Checked %0d cos/sin items from %0d positions after %0d register writes,",
			results_seen, items_taken, regs_written);
		$display("under slow-receiver, slow-sender and back-to-back handshake mixes.");
		if (errors == 0)
			$display("tb_rotary_embedding_cos_sin passed");
		else
			$display("tb_rotary_embedding_cos_sin failed");
		$finish;
	end

endmodule
